[hw/rtl/ppdb_pkg.sv]
// Shared types, field widths and command codes of the temporal delay blend block.
package ppdb_pkg;

	localparam int POS_W           = 12;
	localparam int SAMPLE_W        = 8;
	localparam int DELAY_W         = 12;
	localparam int DELAY_FRAC_BITS = 8;
	localparam int PLANE_W         = 2;
	localparam int CMD_W           = 2;
	localparam int CFG_W           = 5;
	localparam int FRAME_SAMPLES   = 1 << POS_W;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 5;
	localparam int M_TDATA_W = 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int OBUF_DEPTH  = 8;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REAL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

	localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;

	localparam logic [SAMPLE_W-1:0] FILL_LUMA   = 8'd16;
	localparam logic [SAMPLE_W-1:0] FILL_CHROMA = 8'd128;

	localparam logic [CFG_W-1:0] HISTORY_DEPTH_RST = 5'd12;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [POS_W-1:0]    pos;
		logic [PLANE_W-1:0]  plane;
		logic [SAMPLE_W-1:0] sample;
		logic [DELAY_W-1:0]  delay;
	} item_t;

	function automatic logic [SAMPLE_W-1:0] plane_fill(input logic [PLANE_W-1:0] plane);
		logic [SAMPLE_W-1:0] fill;
		case (plane)
			PLANE_LUMA: fill = FILL_LUMA;
			default:    fill = FILL_CHROMA;
		endcase
		return fill;
	endfunction

endpackage

[hw/rtl/per_pixel_temporal_delay_blend_top.sv]
// An accepted pixel item passes the input queue, stages s1 to s4 and the output buffer to m_tvalid.
// Throughput: one item per cycle unless a queue stalls; each real pixel makes one store write
// and every pixel two reads, served by two copies of the frame store, one read port each.
// Reset clears the ring head, slot flags, queues and pipeline valids and sets the depth to 12;
// the delay map and frame store keep their contents and are not cleared.
// Delay loads and unused commands make no result.
module per_pixel_temporal_delay_blend_top import ppdb_pkg::*; #(
	parameter int MAX_HISTORY = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data,   // history_depth
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,    // pixel_index, pixel_sample, delay_value
	input  logic [S_TUSER_W-1:0] s_tuser,    // command, first_of_frame, plane
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata     // out_sample
);

	localparam int SLOT_W    = $clog2(MAX_HISTORY);
	localparam int DEPTH_W   = $clog2(MAX_HISTORY + 1);
	localparam int ITEM_W    = $bits(item_t);
	localparam int Q_W       = ITEM_W + SLOT_W + MAX_HISTORY;
	localparam int DEPTH_RST = (int'(HISTORY_DEPTH_RST) > MAX_HISTORY) ? MAX_HISTORY
		: int'(HISTORY_DEPTH_RST);

	logic [DEPTH_W-1:0]     depth_q;
	logic [DEPTH_W-1:0]     depth_d;

	logic                   q_push;
	logic                   q_pop;
	logic                   q_full;
	logic                   q_empty;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
	logic [Q_W-1:0]         q_wdata;
	logic [Q_W-1:0]         q_rdata;

	item_t                  job_item;
	logic [SLOT_W-1:0]      job_head;
	logic [MAX_HISTORY-1:0] job_valid;

	item_t                  q_item;
	logic [SLOT_W-1:0]      q_head;
	logic [MAX_HISTORY-1:0] q_valid;

	assign cfg_ready = 1'b1;

	// Hold the depth already clamped to the usable range.
	always_comb begin
		if (cfg_data < CFG_W'(2)) begin
			depth_d = DEPTH_W'(2);
		end else if (int'(cfg_data) > MAX_HISTORY) begin
			depth_d = DEPTH_W'(MAX_HISTORY);
		end else begin
			depth_d = DEPTH_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_W'(DEPTH_RST);
		end else if (cfg_valid && cfg_ready) begin
			depth_q <= depth_d;
		end
	end

	ppdb_front #(
		.MAX_HISTORY (MAX_HISTORY)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.depth     (depth_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.q_push    (q_push),
		.job_item  (job_item),
		.job_head  (job_head),
		.job_valid (job_valid)
	);

	assign q_wdata = {job_valid, job_head, job_item};

	ppdb_fifo #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.count  (q_count),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign q_item  = q_rdata[ITEM_W-1:0];
	assign q_head  = q_rdata[ITEM_W+SLOT_W-1:ITEM_W];
	assign q_valid = q_rdata[Q_W-1:ITEM_W+SLOT_W];

	// Queue fill level is not needed beyond its full and empty flags.
	logic unused_count;
	assign unused_count = ^q_count;

	ppdb_back #(
		.MAX_HISTORY (MAX_HISTORY)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.depth    (depth_q),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.q_head   (q_head),
		.q_valid  (q_valid),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[hw/rtl/ppdb_fifo.sv]
// Small first-in first-out queue built from flip-flops.
module ppdb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic [CNT_W-1:0] count,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PTR_W'(DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == PTR_W'(DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign count = count_q;
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

endmodule

[hw/rtl/ppdb_front.sv]
// Front end: takes items, advances the frame ring and tags each item with the ring state.
module ppdb_front import ppdb_pkg::*; #(
	parameter int MAX_HISTORY = 16,
	parameter int SLOT_W      = $clog2(MAX_HISTORY),
	parameter int DEPTH_W     = $clog2(MAX_HISTORY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [DEPTH_W-1:0]     depth,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_TDATA_W-1:0]   s_tdata,   // pixel_index, pixel_sample, delay_value
	input  logic [S_TUSER_W-1:0]   s_tuser,   // command, first_of_frame, plane
	input  logic                   q_full,
	output logic                   q_push,
	output item_t                  job_item,
	output logic [SLOT_W-1:0]      job_head,
	output logic [MAX_HISTORY-1:0] job_valid
);

	localparam int DF_W = ((SLOT_W > DEPTH_W) ? SLOT_W : DEPTH_W) + 1;

	logic [SLOT_W-1:0]      head_q;
	logic [MAX_HISTORY-1:0] valid_q;

	logic                   accept;
	logic                   is_pix;
	logic                   first;
	logic                   advance;
	logic [CMD_W-1:0]       cmd;
	logic [SLOT_W-1:0]      new_head;
	logic [SLOT_W-1:0]      clr_slot;
	logic [DF_W-1:0]        clr_diff;
	logic [MAX_HISTORY-1:0] valid_new;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign cmd      = s_tuser[1:0];
	assign first    = s_tuser[2];

	always_comb begin
		case (cmd)
			CMD_REAL, CMD_FLUSH: is_pix = 1'b1;
			default:             is_pix = 1'b0;
		endcase
	end

	// Unused command code is taken and dropped.
	assign q_push  = accept && (cmd != CMD_NONE);
	assign advance = accept && is_pix && first;

	always_comb begin
		if (head_q == SLOT_W'(MAX_HISTORY - 1)) begin
			new_head = '0;
		end else begin
			new_head = head_q + 1'b1;
		end
		// Slot that falls out of the history window, depth frames behind the new head.
		clr_diff = DF_W'(new_head) - DF_W'(depth);
		if (clr_diff[DF_W-1]) begin
			clr_diff = clr_diff + DF_W'(MAX_HISTORY);
		end
		clr_slot = clr_diff[SLOT_W-1:0];
		for (int i = 0; i < MAX_HISTORY; i++) begin
			if (SLOT_W'(i) == new_head) begin
				valid_new[i] = (cmd == CMD_REAL);
			end else if (SLOT_W'(i) == clr_slot) begin
				valid_new[i] = 1'b0;
			end else begin
				valid_new[i] = valid_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			valid_q <= '0;
		end else if (advance) begin
			head_q  <= new_head;
			valid_q <= valid_new;
		end
	end

	assign job_item.cmd    = cmd;
	assign job_item.pos    = s_tdata[11:0];
	assign job_item.sample = s_tdata[19:12];
	assign job_item.delay  = s_tdata[31:20];
	assign job_item.plane  = s_tuser[4:3];
	assign job_head        = advance ? new_head : head_q;
	assign job_valid       = advance ? valid_new : valid_q;

endmodule

[hw/rtl/ppdb_back.sv]
// Back end: delay map, frame history store, two-tap blend and output buffer.
module ppdb_back import ppdb_pkg::*; #(
	parameter int MAX_HISTORY = 16,
	parameter int SLOT_W      = $clog2(MAX_HISTORY),
	parameter int DEPTH_W     = $clog2(MAX_HISTORY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [DEPTH_W-1:0]     depth,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  item_t                  q_item,
	input  logic [SLOT_W-1:0]      q_head,
	input  logic [MAX_HISTORY-1:0] q_valid,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata    // out_sample
);

	localparam int FRAC      = DELAY_FRAC_BITS;
	localparam int MAXD_W    = DEPTH_W + FRAC;
	localparam int SAT_W     = (DELAY_W > MAXD_W) ? DELAY_W : MAXD_W;
	localparam int WH_W      = SAT_W - FRAC;
	localparam int SD_W      = ((SLOT_W > WH_W) ? SLOT_W : WH_W) + 1;
	localparam int ADDR_W    = SLOT_W + POS_W;
	localparam int MEM_DEPTH = MAX_HISTORY * FRAME_SAMPLES;
	localparam int WGT_W     = FRAC + 1;
	localparam int PROD_W    = SAMPLE_W + WGT_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int OB_CNT_W  = $clog2(OBUF_DEPTH + 1);

	logic [DELAY_W-1:0]  dmap_q [FRAME_SAMPLES];
	logic [SAMPLE_W-1:0] fsa_q  [MEM_DEPTH];
	logic [SAMPLE_W-1:0] fsb_q  [MEM_DEPTH];

	// stage 1: delay map read data
	logic                   vld_s1;
	logic                   real_s1;
	logic [POS_W-1:0]       pos_s1;
	logic [PLANE_W-1:0]     plane_s1;
	logic [SAMPLE_W-1:0]    sample_s1;
	logic [SLOT_W-1:0]      head_s1;
	logic [MAX_HISTORY-1:0] valid_s1;
	logic [DELAY_W-1:0]     dly_s1;

	// stage 2: store addresses
	logic                vld_s2;
	logic                real_s2;
	logic [ADDR_W-1:0]   wr_addr_s2;
	logic [ADDR_W-1:0]   rd0_addr_s2;
	logic [ADDR_W-1:0]   rd1_addr_s2;
	logic [SAMPLE_W-1:0] sample_s2;
	logic                v0_s2;
	logic                v1_s2;
	logic                fwd_s2;
	logic [FRAC-1:0]     frac_s2;
	logic [PLANE_W-1:0]  plane_s2;

	// stage 3: store read data
	logic                vld_s3;
	logic [SAMPLE_W-1:0] rda_s3;
	logic [SAMPLE_W-1:0] rdb_s3;
	logic [SAMPLE_W-1:0] sample_s3;
	logic                v0_s3;
	logic                v1_s3;
	logic                fwd_s3;
	logic [FRAC-1:0]     frac_s3;
	logic [PLANE_W-1:0]  plane_s3;

	// stage 4: weighted products
	logic              vld_s4;
	logic [PROD_W-1:0] p0_s4;
	logic [PROD_W-1:0] p1_s4;

	logic                credit_ok;
	logic [MAXD_W-1:0]   maxd;
	logic [SAT_W-1:0]    dsat;
	logic [WH_W-1:0]     whole;
	logic [SD_W-1:0]     sdiff;
	logic [SLOT_W-1:0]   slot0;
	logic [SLOT_W-1:0]   slot1;
	logic [SAMPLE_W-1:0] tap0;
	logic [SAMPLE_W-1:0] tap1;
	logic [SAMPLE_W-1:0] fill_s3;
	logic [WGT_W-1:0]    wgt0;
	logic [SUM_W-1:0]    sum;
	logic [OB_CNT_W-1:0] ob_count;
	logic                ob_full;
	logic                ob_empty;
	logic                ob_pop;

	// Pop only when the output buffer has room for every result still in flight.
	assign credit_ok = (int'(vld_s1) + int'(vld_s2) + int'(vld_s3) + int'(vld_s4)
		+ int'(ob_count)) < OBUF_DEPTH;
	assign q_pop = !q_empty && credit_ok;

	always_ff @(posedge clk) begin
		if (q_pop && (q_item.cmd == CMD_LOAD)) begin
			dmap_q[q_item.pos] <= q_item.delay;
		end
		dly_s1 <= dmap_q[q_item.pos];
	end

	always_comb begin
		maxd  = {depth - DEPTH_W'(2), {FRAC{1'b0}}};
		dsat  = (SAT_W'(dly_s1) > SAT_W'(maxd)) ? SAT_W'(maxd) : SAT_W'(dly_s1);
		whole = dsat[SAT_W-1:FRAC];
		sdiff = SD_W'(head_s1) - SD_W'(whole);
		if (sdiff[SD_W-1]) begin
			sdiff = sdiff + SD_W'(MAX_HISTORY);
		end
		slot0 = sdiff[SLOT_W-1:0];
		if (slot0 == '0) begin
			slot1 = SLOT_W'(MAX_HISTORY - 1);
		end else begin
			slot1 = slot0 - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && real_s2) begin
			fsa_q[wr_addr_s2] <= sample_s2;
		end
		rda_s3 <= fsa_q[rd0_addr_s2];
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && real_s2) begin
			fsb_q[wr_addr_s2] <= sample_s2;
		end
		rdb_s3 <= fsb_q[rd1_addr_s2];
	end

	always_comb begin
		fill_s3 = plane_fill(plane_s3);
		// The current frame is written in the same cycle it is read: bypass the store.
		if (!v0_s3) begin
			tap0 = fill_s3;
		end else if (fwd_s3) begin
			tap0 = sample_s3;
		end else begin
			tap0 = rda_s3;
		end
		tap1 = v1_s3 ? rdb_s3 : fill_s3;
		wgt0 = WGT_W'(1 << FRAC) - WGT_W'(frac_s3);
	end

	assign sum = SUM_W'(p0_s4) + SUM_W'(p1_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= q_pop && (q_item.cmd != CMD_LOAD);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		real_s1   <= (q_item.cmd == CMD_REAL);
		pos_s1    <= q_item.pos;
		plane_s1  <= q_item.plane;
		sample_s1 <= q_item.sample;
		head_s1   <= q_head;
		valid_s1  <= q_valid;

		real_s2     <= real_s1;
		wr_addr_s2  <= {head_s1, pos_s1};
		rd0_addr_s2 <= {slot0, pos_s1};
		rd1_addr_s2 <= {slot1, pos_s1};
		sample_s2   <= sample_s1;
		v0_s2       <= valid_s1[slot0];
		v1_s2       <= valid_s1[slot1];
		fwd_s2      <= real_s1 && (whole == '0);
		frac_s2     <= dsat[FRAC-1:0];
		plane_s2    <= plane_s1;

		sample_s3 <= sample_s2;
		v0_s3     <= v0_s2;
		v1_s3     <= v1_s2;
		fwd_s3    <= fwd_s2;
		frac_s3   <= frac_s2;
		plane_s3  <= plane_s2;

		p0_s4 <= PROD_W'(tap0) * PROD_W'(wgt0);
		p1_s4 <= PROD_W'(tap1) * PROD_W'(frac_s3);
	end

	assign ob_pop   = m_tvalid && m_tready;
	assign m_tvalid = !ob_empty;

	ppdb_fifo #(
		.WIDTH (M_TDATA_W),
		.DEPTH (OBUF_DEPTH)
	) u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (vld_s4),
		.wdata  (sum[FRAC+SAMPLE_W-1:FRAC]),
		.pop    (ob_pop),
		.rdata  (m_tdata),
		.count  (ob_count),
		.full   (ob_full),
		.empty  (ob_empty)
	);

	// Credit check keeps the buffer from overflowing; full only gates nothing here.
	logic unused_full;
	assign unused_full = ob_full;

endmodule

[tb/tb_per_pixel_temporal_delay_blend_top.sv]
// Testbench for the temporal delay blend block: frame streams checked against a predictor.
`timescale 1ns / 1ps
module tb_per_pixel_temporal_delay_blend_top;
	import ppdb_pkg::*;

	localparam int HIST_SLOTS  = 16;
	localparam int SLOT_W      = $clog2(HIST_SLOTS);
	localparam int POS_COUNT   = 8;
	localparam int LATENCY     = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 50;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic                first;
		logic [POS_W-1:0]    pos;
		logic [PLANE_W-1:0]  plane;
		logic [SAMPLE_W-1:0] sample;
		logic [DELAY_W-1:0]  delay;
	} pix_item_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data  = '0;   // history_depth
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;   // pixel_index, pixel_sample, delay_value
	logic [S_TUSER_W-1:0] s_tuser   = '0;   // command, first_of_frame, plane
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;          // out_sample

	// predictor state
	logic [DELAY_W-1:0]  delay_tbl [FRAME_SAMPLES];
	logic [SAMPLE_W-1:0] frame_mem [HIST_SLOTS][FRAME_SAMPLES];
	bit                  slot_full [HIST_SLOTS];
	logic [SLOT_W-1:0]   head_slot = '0;
	logic [CFG_W-1:0]    depth_reg = HISTORY_DEPTH_RST;
	logic [SAMPLE_W-1:0] pending_samples [$];

	// positions every real frame covers, so no history read hits an unwritten byte
	logic [POS_W-1:0] pos_set [POS_COUNT];

	int error_count     = 0;
	int cycle_count     = 0;
	int burst_left      = 0;
	int hold_off_cycles = 0;

	per_pixel_temporal_delay_blend_top #(
		.MAX_HISTORY(HIST_SLOTS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial forever #6 clk = ~clk;

	function automatic int unsigned depth_used();
		if (depth_reg < 2) return 2;
		if (depth_reg > HIST_SLOTS) return HIST_SLOTS;
		return 32'(depth_reg);
	endfunction

	function automatic int unsigned slot_back(input int unsigned back);
		return (head_slot + HIST_SLOTS - back % HIST_SLOTS) % HIST_SLOTS;
	endfunction

	function automatic int unsigned history_sample(input int unsigned back,
			input logic [POS_W-1:0] pos, input logic [PLANE_W-1:0] plane);
		int unsigned slot;
		slot = slot_back(back);
		if (!slot_full[SLOT_W'(slot)])
			return 32'((plane == PLANE_LUMA) ? FILL_LUMA : FILL_CHROMA);
		return 32'(frame_mem[SLOT_W'(slot)][pos]);
	endfunction

	function automatic void predict_blend(input pix_item_t it);
		int unsigned depth, cap, dv, whole, frac, near_s, far_s, acc;
		if (it.cmd == CMD_LOAD) begin
			delay_tbl[it.pos] = it.delay;
			return;
		end
		if (it.cmd == CMD_NONE) return;
		depth = depth_used();
		if (it.first) begin
			head_slot = head_slot + 1'b1;
			slot_full[SLOT_W'(slot_back(depth))] = 1'b0;
			slot_full[head_slot] = (it.cmd == CMD_REAL);
		end
		if (it.cmd == CMD_REAL) frame_mem[head_slot][it.pos] = it.sample;
		cap = (depth - 2) << DELAY_FRAC_BITS;
		dv = 32'(delay_tbl[it.pos]);
		if (dv > cap) dv = cap;
		whole = dv >> DELAY_FRAC_BITS;
		frac = dv & ((1 << DELAY_FRAC_BITS) - 1);
		near_s = history_sample(whole, it.pos, it.plane);
		far_s = history_sample(whole + 1, it.pos, it.plane);
		acc = (near_s * ((1 << DELAY_FRAC_BITS) - frac) + far_s * frac) >> DELAY_FRAC_BITS;
		pending_samples.push_back(acc[SAMPLE_W-1:0]);
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [DELAY_W-1:0] rand_delay();
		int unsigned whole;
		whole = $urandom_range(0, depth_used());
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return DELAY_W'($urandom_range(0, 4095));
			4: return DELAY_W'(whole << DELAY_FRAC_BITS);
			default: return DELAY_W'((whole << DELAY_FRAC_BITS) | $urandom_range(0, 255));
		endcase
	endfunction

	// Offer one item in bursts with random gaps; predict it on acceptance.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic first,
			input logic [POS_W-1:0] pos, input logic [PLANE_W-1:0] plane,
			input logic [SAMPLE_W-1:0] sample, input logic [DELAY_W-1:0] delay);
		pix_item_t it;
		int gap;
		it = '{cmd, first, pos, plane, sample, delay};
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {it.delay, it.sample, it.pos};
		s_tuser  <= {it.plane, it.first, it.cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_blend(it);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_samples.size() != 0) @(posedge clk);
		// loads make no result; let any still in flight land
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_depth(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		depth_reg = value;
	endtask

	// safe_pos must already hold this frame's sample if the head slot is a real frame
	task automatic send_noise(input logic [POS_W-1:0] safe_pos);
		case ($urandom_range(0, 4))
			0: send_item(CMD_LOAD, 1'($urandom_range(0, 1)),
				$urandom_range(0, 1) ? safe_pos : POS_W'($urandom_range(0, 4095)),
				PLANE_W'($urandom_range(0, 3)), rand_sample(), rand_delay());
			1: send_item(CMD_NONE, 1'($urandom_range(0, 1)), POS_W'($urandom_range(0, 4095)),
				PLANE_W'($urandom_range(0, 3)), rand_sample(),
				DELAY_W'($urandom_range(0, 4095)));
			2: send_item(CMD_FLUSH, 1'b0, safe_pos, PLANE_W'($urandom_range(0, 3)),
				rand_sample(), DELAY_W'($urandom_range(0, 4095)));
			default: send_item(CMD_REAL, 1'b0, safe_pos, PLANE_W'($urandom_range(0, 3)),
				rand_sample(), DELAY_W'($urandom_range(0, 4095)));
		endcase
	endtask

	task automatic send_frame(input bit real_frame);
		int order [POS_COUNT];
		int j, tmp;
		for (int i = 0; i < POS_COUNT; i++) order[i] = i;
		for (int i = POS_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		if (real_frame) begin
			for (int i = 0; i < POS_COUNT; i++) begin
				if (i > 0 && $urandom_range(0, 4) == 0)
					send_noise(pos_set[order[$urandom_range(0, i - 1)]]);
				send_item(CMD_REAL, i == 0, pos_set[order[i]], PLANE_W'($urandom_range(0, 3)),
					rand_sample(), DELAY_W'($urandom_range(0, 4095)));
			end
		end else begin
			send_item(CMD_FLUSH, 1'b1, pos_set[order[0]], PLANE_W'($urandom_range(0, 3)),
				rand_sample(), DELAY_W'($urandom_range(0, 4095)));
			repeat ($urandom_range(0, POS_COUNT - 1))
				send_noise(pos_set[$urandom_range(0, POS_COUNT - 1)]);
		end
	endtask

	task automatic test_directed_cases();
		logic [DELAY_W-1:0] edge_delays [POS_COUNT] = '{12'h000, 12'hFFF, 12'h080, 12'h1FF,
			12'h100, 12'hA00, 12'hA01, 12'h001};
		for (int i = 0; i < POS_COUNT; i++)
			send_item(CMD_LOAD, 1'b0, pos_set[i], PLANE_LUMA, '0, edge_delays[i]);
		// unused command with every other field at its top must not advance the ring
		send_item(CMD_NONE, 1'b1, '1, '1, '1, '1);
		for (int i = 0; i < POS_COUNT; i++)
			send_item(CMD_REAL, i == 0, pos_set[i], PLANE_W'(i % 4),
				(i % 3 == 0) ? '0 : ((i % 3 == 1) ? '1 : rand_sample()), '1);
		send_item(CMD_FLUSH, 1'b1, pos_set[0], PLANE_LUMA, '1, '0);
		send_item(CMD_FLUSH, 1'b0, pos_set[2], 2'd1, '0, '1);
		send_item(CMD_LOAD, 1'b1, pos_set[7], 2'd3, '1, 12'h0FF);
		wait_idle();
	endtask

	task automatic test_depth_sweep();
		logic [CFG_W-1:0] depths [9] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd3, 5'd9,
			5'd12};
		for (int d = 0; d < 9; d++) begin
			write_depth(depths[d]);
			for (int i = 0; i < POS_COUNT; i++)
				if ($urandom_range(0, 1))
					send_item(CMD_LOAD, 1'($urandom_range(0, 1)), pos_set[i],
						PLANE_W'($urandom_range(0, 3)), rand_sample(), rand_delay());
			repeat ($urandom_range(9, 14)) send_frame($urandom_range(0, 3) != 0);
		end
	endtask

	task automatic test_output_backpressure();
		hold_off_cycles = 200;
		repeat (4) send_frame(1'b1);
	endtask

	task automatic test_drain_pause();
		repeat (3) send_frame($urandom_range(0, 3) != 0);
		wait_idle();
		repeat (3) send_frame($urandom_range(0, 3) != 0);
	endtask

	// receiver: own stall pattern, plus a long hold-off on request
	initial begin
		int mode, mode_left, phase;
		mode = 0;
		mode_left = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			phase = (phase + 1) % 5;
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (phase < 3);
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin
		logic [SAMPLE_W-1:0] want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_samples.size() == 0) begin
					if (error_count < PRINT_LIMIT)
						$display("%0t: out_sample %0d arrived with none expected", $time, m_tdata);
					error_count++;
				end else begin
					want = pending_samples.pop_front();
					if (m_tdata !== want) begin
						if (error_count < PRINT_LIMIT)
							$display("%0t: out_sample mismatch, expected %0d, got %0d",
								$time, want, m_tdata);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		bit dup;
		for (int i = 0; i < HIST_SLOTS; i++) slot_full[i] = 1'b0;
		pos_set[0] = '0;
		pos_set[1] = '1;
		for (int i = 2; i < POS_COUNT; i++) begin
			do begin
				pos_set[i] = POS_W'($urandom_range(1, FRAME_SAMPLES - 2));
				dup = 1'b0;
				for (int j = 0; j < i; j++) if (pos_set[j] == pos_set[i]) dup = 1'b1;
			end while (dup);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_depth_sweep();
		test_output_backpressure();
		test_drain_pause();
		wait_idle();
		if (error_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
